FILE: design/npsrch_pkg.sv
// npsrch_pkg: shared constants, types and the control store of the next-prime search.
// No dependencies. Used by the channel interfaces, the remainder unit and the top level.
`default_nettype none

package npsrch_pkg;

  // Default width of the value fields
  localparam int unsigned NPS_VALUE_WIDTH = 24;

  // Microprogram addresses
  typedef enum logic [3:0] {
    S_EMIT      = 4'd0,
    S_IDLE      = 4'd1,
    S_CHK_SMALL = 4'd2,
    S_CHK_SQ    = 4'd3,
    S_DIV_GO    = 4'd4,
    S_DIV_WAIT  = 4'd5,
    S_DIV_TEST  = 4'd6,
    S_STEP      = 4'd7,
    S_NOTPRIME  = 4'd8,
    S_ISPRIME   = 4'd9,
    S_DECIDE    = 4'd10,
    S_NEXT      = 4'd11,
    S_INC       = 4'd12,
    S_OVF       = 4'd13
  } step_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    A_NONE      = 4'd0,
    A_LOAD      = 4'd1,
    A_INIT_D    = 4'd2,
    A_DIV_START = 4'd3,
    A_STEP_D    = 4'd4,
    A_SET_PRIME = 4'd5,
    A_CLR_PRIME = 4'd6,
    A_RECORD    = 4'd7,
    A_INC_CAND  = 4'd8,
    A_OVF       = 4'd9,
    A_EMIT      = 4'd10
  } action_t;

  // Jump conditions; a false condition falls through to the next address
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_BEAT   = 4'd2,
    C_LT2       = 4'd3,
    C_SQ_GT     = 4'd4,
    C_DIV_BUSY  = 4'd5,
    C_REM_ZERO  = 4'd6,
    C_DONE      = 4'd7,
    C_AT_MAX    = 4'd8,
    C_OUT_BUSY  = 4'd9
  } cond_t;

  typedef struct packed {
    action_t action;
    cond_t   cond;
    step_t   target;
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t npsrch_rom(input step_t s);
    ctrl_word_t w;
    w = '{action: A_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (s)
      S_EMIT:      w = '{action: A_EMIT,      cond: C_OUT_BUSY, target: S_EMIT};
      S_IDLE:      w = '{action: A_LOAD,      cond: C_NO_BEAT,  target: S_IDLE};
      S_CHK_SMALL: w = '{action: A_INIT_D,    cond: C_LT2,      target: S_NOTPRIME};
      S_CHK_SQ:    w = '{action: A_NONE,      cond: C_SQ_GT,    target: S_ISPRIME};
      S_DIV_GO:    w = '{action: A_DIV_START, cond: C_NEVER,    target: S_IDLE};
      S_DIV_WAIT:  w = '{action: A_NONE,      cond: C_DIV_BUSY, target: S_DIV_WAIT};
      S_DIV_TEST:  w = '{action: A_NONE,      cond: C_REM_ZERO, target: S_NOTPRIME};
      S_STEP:      w = '{action: A_STEP_D,    cond: C_ALWAYS,   target: S_CHK_SQ};
      S_NOTPRIME:  w = '{action: A_CLR_PRIME, cond: C_ALWAYS,   target: S_DECIDE};
      S_ISPRIME:   w = '{action: A_SET_PRIME, cond: C_NEVER,    target: S_IDLE};
      S_DECIDE:    w = '{action: A_RECORD,    cond: C_DONE,     target: S_EMIT};
      S_NEXT:      w = '{action: A_NONE,      cond: C_AT_MAX,   target: S_OVF};
      S_INC:       w = '{action: A_INC_CAND,  cond: C_ALWAYS,   target: S_CHK_SMALL};
      S_OVF:       w = '{action: A_OVF,       cond: C_ALWAYS,   target: S_EMIT};
      default:     w = '{action: A_NONE,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/npsrch_in_if.sv
// npsrch_in_if: request channel (operation select and start value).
// Depends on npsrch_pkg for the default width.
`default_nettype none

interface npsrch_in_if #(
  parameter int unsigned VALUE_WIDTH = npsrch_pkg::NPS_VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [VALUE_WIDTH-1:0] start_value;

  modport source (output valid, output func, output start_value, input ready);
  modport sink   (input valid, input func, input start_value, output ready);
endinterface

`default_nettype wire

FILE: design/npsrch_out_if.sv
// npsrch_out_if: result channel (prime value, prime flag, overflow).
// Depends on npsrch_pkg for the default width.
`default_nettype none

interface npsrch_out_if #(
  parameter int unsigned VALUE_WIDTH = npsrch_pkg::NPS_VALUE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] prime_value;
  logic                   is_prime_flag;
  logic                   overflow;

  modport source (output valid, output prime_value, output is_prime_flag,
                  output overflow, input ready);
  modport sink   (input valid, input prime_value, input is_prime_flag,
                  input overflow, output ready);
endinterface

`default_nettype wire

FILE: design/npsrch_rem.sv
// npsrch_rem: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on npsrch_pkg for the default width.
`default_nettype none

module npsrch_rem #(
  parameter int unsigned VALUE_WIDTH = npsrch_pkg::NPS_VALUE_WIDTH,
  parameter int unsigned DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0]   divisor,
  output logic                        busy,
  output logic [DIV_WIDTH-1:0]        remainder
);
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]       count;
  logic [DIV_WIDTH:0]     rem_sh;
  logic [DIV_WIDTH:0]     rem_diff;
  logic                   fits;

  // One restoring step
  always_comb begin
    rem_sh   = {remainder, shreg[VALUE_WIDTH-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
  end

  // Control: busy from start until every dividend bit has been shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(VALUE_WIDTH);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= {shreg[VALUE_WIDTH-2:0], 1'b0};
      remainder <= fits ? rem_diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/next_prime_search.sv
// next_prime_search: primality test and next-prime search by trial division.
// Depends on npsrch_pkg, npsrch_in_if, npsrch_out_if and npsrch_rem.
`default_nettype none

//  channel   dir  payload                                   handshake
//  items     in   func, start_value[VALUE_WIDTH]            valid/ready
//  results   out  prime_value[VALUE_WIDTH], is_prime_flag,  valid/ready
//                 overflow
//
//  One item at a time. Each trial divisor is tested by the bit-serial remainder
//  unit; a candidate n costs up to about sqrt(n) trials, and a search repeats
//  this per candidate until a prime is found or the value range runs out.
//  Reset (rst, synchronous) returns the sequencer to its idle address and
//  drops results.valid. A stalled result is held in the output register; the
//  next item is taken while it waits, and the sequencer holds at its emit
//  step until the register frees up.

module next_prime_search #(
  parameter int unsigned VALUE_WIDTH = npsrch_pkg::NPS_VALUE_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  npsrch_in_if.sink    items,
  npsrch_out_if.source results
);
  import npsrch_pkg::*;

  localparam int unsigned DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned SQ_WIDTH  = VALUE_WIDTH + 2;

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t ctrl;
  logic       take_jump;

  logic [VALUE_WIDTH-1:0] cand;
  logic                   func;
  logic                   first;
  logic                   prime;
  logic                   flag;
  logic                   ovf;
  logic [DIV_WIDTH-1:0]   d;
  logic [SQ_WIDTH-1:0]    sq;

  logic                   div_busy;
  logic [DIV_WIDTH-1:0]   rem;
  logic                   beat_in;
  logic                   out_free;

  npsrch_rem #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_WIDTH   (DIV_WIDTH)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (ctrl.action == A_DIV_START),
    .dividend  (cand),
    .divisor   (d),
    .busy      (div_busy),
    .remainder (rem)
  );

  assign ctrl         = npsrch_rom(pc);
  assign items.ready  = (ctrl.action == A_LOAD);
  assign beat_in      = items.valid && items.ready;
  assign out_free     = !results.valid || results.ready;

  // Condition select and next address
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take_jump = 1'b0;
      C_ALWAYS:   take_jump = 1'b1;
      C_NO_BEAT:  take_jump = !items.valid;
      C_LT2:      take_jump = (cand[VALUE_WIDTH-1:1] == '0);
      C_SQ_GT:    take_jump = (sq > {2'b00, cand});
      C_DIV_BUSY: take_jump = div_busy;
      C_REM_ZERO: take_jump = (rem == '0);
      C_DONE:     take_jump = !func || prime;
      C_AT_MAX:   take_jump = &cand;
      C_OUT_BUSY: take_jump = !out_free;
      default:    take_jump = 1'b0;
    endcase
    pc_next = take_jump ? ctrl.target : step_t'(pc + 4'd1);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath driven by the control word
  always_ff @(posedge clk) begin
    case (ctrl.action)
      A_LOAD: begin
        if (beat_in) begin
          cand  <= items.start_value;
          func  <= items.func;
          first <= 1'b1;
          ovf   <= 1'b0;
        end
      end
      A_INIT_D: begin
        d  <= DIV_WIDTH'(2);
        sq <= SQ_WIDTH'(4);
      end
      A_STEP_D: begin
        d  <= d + 1'b1;
        sq <= sq + SQ_WIDTH'({d, 1'b1});
      end
      A_SET_PRIME: prime <= 1'b1;
      A_CLR_PRIME: prime <= 1'b0;
      A_RECORD: begin
        if (first) begin
          flag <= prime;
        end
        first <= 1'b0;
      end
      A_INC_CAND: cand <= cand + 1'b1;
      A_OVF: begin
        ovf  <= 1'b1;
        cand <= '0;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctrl.action == A_EMIT && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.action == A_EMIT && out_free) begin
      results.prime_value   <= cand;
      results.is_prime_flag <= flag;
      results.overflow      <= ovf;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking bench for next_prime_search (primality test and next-prime search).
// Depends on npsrch_pkg, npsrch_in_if, npsrch_out_if and the next_prime_search top level.

module tb;

  localparam int unsigned W = npsrch_pkg::NPS_VALUE_WIDTH;
  localparam longint unsigned VALUE_MAX = (64'd1 << W) - 1;

  // Operation select codes
  localparam logic OP_TEST   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam int RANDOM_ITEMS = 119;
  localparam int PHASE_LEN    = 16;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic         func;
    logic [W-1:0] value;
  } prime_req_t;

  typedef struct {
    logic         func;
    logic [W-1:0] start;
    logic [W-1:0] value;
    logic         prime;
    logic         ovf;
  } prime_result_t;

  logic clk;
  logic rst;

  npsrch_in_if  #(.VALUE_WIDTH(W)) req_if ();
  npsrch_out_if #(.VALUE_WIDTH(W)) res_if ();

  next_prime_search #(.VALUE_WIDTH(W)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (req_if.sink),
    .results (res_if.source)
  );

  prime_req_t    pending_requests[$];
  prime_result_t awaited_results[$];
  prime_req_t    next_req;
  prime_result_t want;
  int            n_sent;
  int            mismatches;

  // Trial division by every d with d*d <= n
  function automatic bit value_is_prime(input logic [W-1:0] n);
    longint unsigned nn;
    longint unsigned d;
    nn = 64'(n);
    if (nn < 2) return 1'b0;
    for (d = 2; d * d <= nn; d++) begin
      if (nn % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result beat for one request
  function automatic prime_result_t predict_prime(input logic func, input logic [W-1:0] value);
    prime_result_t r;
    longint unsigned c;
    r.func  = func;
    r.start = value;
    r.prime = value_is_prime(value);
    r.value = value;
    r.ovf   = 1'b0;
    if (func == OP_SEARCH) begin
      c = 64'(value);
      while (c <= VALUE_MAX && !value_is_prime(c[W-1:0])) c++;
      if (c > VALUE_MAX) begin
        r.value = '0;
        r.ovf   = 1'b1;
      end else begin
        r.value = c[W-1:0];
      end
    end
    return r;
  endfunction

  // Idle and stall rates per phase: none, sender, receiver, both
  function automatic int sender_idle_pct(input int sent);
    case ((sent / PHASE_LEN) % 4)
      1: return 60;
      3: return 36;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int sent);
    case ((sent / PHASE_LEN) % 4)
      2: return 60;
      3: return 36;
      default: return 0;
    endcase
  endfunction

  task automatic add_req(input logic func, input logic [W-1:0] value);
    prime_req_t r;
    r.func  = func;
    r.value = value;
    pending_requests.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: one request beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_results.push_back(predict_prime(req_if.func, req_if.start_value));
        n_sent <= n_sent + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct(n_sent)) begin
          next_req = pending_requests.pop_front();
          req_if.valid       <= 1'b1;
          req_if.func        <= next_req.func;
          req_if.start_value <= next_req.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing awaited: value=%0d",
                                    res_if.prime_value));
        end else begin
          want = awaited_results.pop_front();
          if (res_if.prime_value !== want.value)
            report_mismatch($sformatf("func=%0d start=%0d prime_value=%0d want %0d",
                                      want.func, want.start, res_if.prime_value, want.value));
          if (res_if.is_prime_flag !== want.prime)
            report_mismatch($sformatf("func=%0d start=%0d is_prime_flag=%0d want %0d",
                                      want.func, want.start, res_if.is_prime_flag,
                                      want.prime));
          if (res_if.overflow !== want.ovf)
            report_mismatch($sformatf("func=%0d start=%0d overflow=%0d want %0d",
                                      want.func, want.start, res_if.overflow, want.ovf));
        end
      end
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct(n_sent));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned pick;
    logic [W-1:0] v;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.func        = OP_TEST;
    req_if.start_value = '0;
    res_if.ready       = 1'b0;
    n_sent             = 0;
    mismatches         = 0;

    // Directed: small values, both modes, top of range and overflow
    add_req(OP_TEST, 0);
    add_req(OP_TEST, 1);
    add_req(OP_TEST, 2);
    add_req(OP_TEST, 3);
    add_req(OP_TEST, 4);
    add_req(OP_TEST, 9);
    add_req(OP_TEST, 25);
    add_req(OP_TEST, 97);
    add_req(OP_SEARCH, 0);
    add_req(OP_SEARCH, 1);
    add_req(OP_SEARCH, 2);
    add_req(OP_SEARCH, 3);
    add_req(OP_SEARCH, 4);
    add_req(OP_SEARCH, 14);
    add_req(OP_SEARCH, 24);
    add_req(OP_TEST, VALUE_MAX[W-1:0]);
    add_req(OP_TEST, W'(VALUE_MAX - 1));
    add_req(OP_TEST, W'(VALUE_MAX - 2));
    add_req(OP_SEARCH, W'(VALUE_MAX - 3));
    add_req(OP_SEARCH, W'(VALUE_MAX - 1));
    add_req(OP_SEARCH, VALUE_MAX[W-1:0]);

    // Random: mostly small values, a few full-width ones for the high bits
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) v = W'($urandom_range(1023));
      else if (pick < 97) v = W'($urandom_range(16383));
      else v = W'($urandom());
      add_req(1'($urandom_range(1)), v);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_requests.size() == 0 && req_if.valid == 1'b0);
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #480_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
design/npsrch_pkg.sv
design/npsrch_in_if.sv
design/npsrch_out_if.sv
design/npsrch_rem.sv
design/next_prime_search.sv
tb/sv/tb.sv
